/* src/assert_macros.svh */
// Assertion macros for the RTL files (included by the simplifier top level).
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALW(label, prop, msg)
`endif
`endif

/* src/gps_pkg.sv */
// Types and constants for the greedy polyline simplifier.
// No dependencies.
package gps_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DEF_MAX_RUN = 64;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  line_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] kept_x;
    logic [COORD_BITS-1:0] kept_y;
    logic                  kept_last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_D2A,   // d2  = bx*bx
    OP_D2B,   // d2 += by*by
    OP_M1,    // n   = bx*uy
    OP_M2,    // n  -= by*ux
    OP_NN     // compare 4*n*n against d2
  } tol_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_D2A,
    S_D2B,
    S_M1,
    S_M2,
    S_NN,
    S_DECIDE,
    S_EMIT_A,
    S_FINISH
  } state_t;

endpackage

/* src/gps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on gps_pkg for default sizes.
module gps_ram import gps_pkg::*; #(
  parameter int WIDTH = 2 * COORD_BITS,
  parameter int DEPTH = DEF_MAX_RUN
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gps_tol_unit.sv */
// Shared multiplier datapath for the half-pixel distance test.
// Depends on gps_pkg; sequenced one operation per cycle by the top level.
module gps_tol_unit import gps_pkg::*; (
  input  logic    clk,
  input  tol_op_t op,
  input  point_t  p,
  input  point_t  a,
  input  point_t  t,
  output logic    breach
);

  localparam int DW = 2 * COORD_BITS + 1;   // d2 width
  localparam int PW = 2 * COORD_BITS + 2;   // product width
  localparam int NW = 2 * COORD_BITS + 3;   // cross product width

  logic signed [COORD_BITS:0] bx, by, ux, uy;
  logic signed [COORD_BITS:0] ma, mb;
  logic signed [PW-1:0]       prod;
  logic signed [NW-1:0]       prod_ext;
  logic [DW-1:0]              d2_r;
  logic signed [NW-1:0]       n_r;
  logic [NW-1:0]              nabs;
  logic                       big;

  assign bx = $signed({1'b0, p.x}) - $signed({1'b0, a.x});
  assign by = $signed({1'b0, p.y}) - $signed({1'b0, a.y});
  assign ux = $signed({1'b0, t.x}) - $signed({1'b0, a.x});
  assign uy = $signed({1'b0, t.y}) - $signed({1'b0, a.y});

  assign nabs = n_r[NW-1] ? NW'(-n_r) : NW'(n_r);
  // |n| of 2^COORD_BITS or more always beats d2, which stays below 2^(2*COORD_BITS+1)
  assign big  = |nabs[NW-1:COORD_BITS];

  always_comb begin
    case (op)
      OP_D2A:  begin ma = bx; mb = bx; end
      OP_D2B:  begin ma = by; mb = by; end
      OP_M1:   begin ma = bx; mb = uy; end
      OP_M2:   begin ma = by; mb = ux; end
      OP_NN:   begin
        ma = $signed({1'b0, nabs[COORD_BITS-1:0]});
        mb = $signed({1'b0, nabs[COORD_BITS-1:0]});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = {prod[PW-1], prod};

  always_ff @(posedge clk) begin
    case (op)
      OP_D2A:  d2_r <= prod[DW-1:0];
      OP_D2B:  d2_r <= d2_r + prod[DW-1:0];
      OP_M1:   n_r  <= prod_ext;
      OP_M2:   n_r  <= n_r - prod_ext;
      default: ;
    endcase
  end

  assign breach = (op == OP_NN) &&
                  (big || ({prod[2*COORD_BITS-1:0], 2'b00} >= {1'b0, d2_r}));

endmodule

/* src/greedy_polyline_simplifier.sv */
// Greedy polyline simplifier: one point per transfer in, kept points out.
// One point at a time: a line's first point takes S_FIRST; others take S_D2A and S_D2B
// (non-empty run only), multiplier steps S_M1, S_M2, S_NN per run point until a breach or
// the run's end, S_DECIDE, S_EMIT_A when an anchor point is emitted, and S_FINISH. Output
// stalls hold emit steps. Results are registered, seen the cycle after their emit step.
// Synchronous active-low reset closes any open line and empties the run.
module greedy_polyline_simplifier import gps_pkg::*; #(
  parameter int MAX_RUN = DEF_MAX_RUN
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_RUN + 1);
  localparam int AW = $clog2(MAX_RUN);

  state_t          state_r, state_nxt;
  point_t          anchor_r, anchor_nxt;
  point_t          p_r, p_nxt;
  point_t          last_pt_r, last_pt_nxt;
  logic            last_r, last_nxt;
  logic            line_open_r, line_open_nxt;
  logic            hit_r, hit_nxt;
  logic [CW-1:0]   run_cnt_r, run_cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  tol_op_t         op;
  logic            breach;
  logic            out_free;
  logic            out_load;
  logic            we;
  point_t          rd_pt;
  logic            run_full;

  gps_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_RUN)
  ) u_run (
    .clk   (clk),
    .we    (we),
    .waddr (run_cnt_r[AW-1:0]),
    .wdata (p_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_pt)
  );

  gps_tol_unit u_tol (
    .clk    (clk),
    .op     (op),
    .p      (p_r),
    .a      (anchor_r),
    .t      (rd_pt),
    .breach (breach)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign run_full = (run_cnt_r == CW'(MAX_RUN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      anchor_r    <= '0;
      line_open_r <= 1'b0;
      hit_r       <= 1'b0;
      run_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      anchor_r    <= anchor_nxt;
      line_open_r <= line_open_nxt;
      hit_r       <= hit_nxt;
      run_cnt_r   <= run_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r       <= p_nxt;
    last_r    <= last_nxt;
    last_pt_r <= last_pt_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    anchor_nxt    = anchor_r;
    p_nxt         = p_r;
    last_pt_nxt   = last_pt_r;
    last_nxt      = last_r;
    line_open_nxt = line_open_r;
    hit_nxt       = hit_r;
    run_cnt_nxt   = run_cnt_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    op            = OP_NONE;
    we            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt    = '{x: in_data.px, y: in_data.py};
          last_nxt = in_data.line_end;
          hit_nxt  = 1'b0;
          idx_nxt  = '0;
          if (!line_open_r) begin
            state_nxt = S_FIRST;
          end else if (run_cnt_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_D2A;
          end
        end
      end
      S_FIRST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '{kept_x: p_r.x, kept_y: p_r.y, kept_last: last_r};
          if (!last_r) begin
            anchor_nxt    = p_r;
            run_cnt_nxt   = '0;
            line_open_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_D2A: begin
        op        = OP_D2A;
        state_nxt = S_D2B;
      end
      S_D2B: begin
        op        = OP_D2B;
        state_nxt = S_M1;
      end
      S_M1: begin
        op        = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        // read data of this entry is consumed; start fetching the next one
        op        = OP_M2;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_NN;
      end
      S_NN: begin
        op = OP_NN;
        if (breach) begin
          hit_nxt = 1'b1;
        end
        if (breach || idx_r == run_cnt_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_M1;
        end
      end
      S_DECIDE: begin
        if (hit_r || (!last_r && run_full)) begin
          state_nxt = S_EMIT_A;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_nxt     = '{kept_x: last_pt_r.x, kept_y: last_pt_r.y, kept_last: 1'b0};
          anchor_nxt  = last_pt_r;
          run_cnt_nxt = '0;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (last_r) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_nxt       = '{kept_x: p_r.x, kept_y: p_r.y, kept_last: 1'b1};
            line_open_nxt = 1'b0;
            run_cnt_nxt   = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          we          = 1'b1;
          last_pt_nxt = p_r;
          run_cnt_nxt = run_cnt_r + 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_RST(a_closed_line_empty, (state_r == S_IDLE && !line_open_r) |-> (run_cnt_r == '0), "run not empty while no line is open")
  `ASSERT_RST(a_idx_in_run, (run_cnt_r <= CW'(MAX_RUN)) && ((state_r != S_M1 && state_r != S_M2) || (idx_r < run_cnt_r)), "scan index or run count out of range")
  `ASSERT_RST(a_last_closes, (out_valid && !out_stall && out_data.kept_last) |-> !line_open_r, "line still open when its last point transfers")

endmodule
